// ----- rtl/krt_pkg.sv -----
// ----------------------------------------------------------------------------
// krt_pkg
// Shared widths, defaults and codes for the keyed record table.
// ----------------------------------------------------------------------------
package krt_pkg;

  // Fixed field widths of the request and result words
  localparam int MODE_W      = 2;
  localparam int KEY_W       = 32;
  localparam int NAME_PORT_W = 64;
  localparam int STATUS_W    = 2;

  // Default table geometry
  localparam int ENTRIES_DEF    = 128;
  localparam int NAME_BYTES_DEF = 8;

  // Request operation codes
  typedef enum logic [MODE_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SELECT = 2'd2,
    OP_UPDATE = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

endpackage

// ----- rtl/keyed_record_table_unit.sv -----
// ----------------------------------------------------------------------------
// keyed_record_table_unit
// Insertion-ordered key/name record table with insert, delete, select and update.
// ----------------------------------------------------------------------------
// Raise start for one cycle while busy is low to hand in a request word; busy
// stays high until the result word appears, for one cycle only, with done
// high, so the receiver must take it then. Records live in one RAM with a
// single read port, and the sequencer walks it one entry per cycle with a
// single key comparator. Insert writes at the entry count (or reports full)
// in the dispatch state and posts its result there, as does any other request
// on an empty table. Select, update and delete read from index 0 up until the
// key hits; a miss reads every entry first. A delete that hits then moves each
// later record down by one to close the gap, one record moved per cycle. A new
// request is accepted in the cycle the result strobe is shown. After reset the
// entry count is cleared but not the RAM; entries at or above it are never used
// before an insert writes them, so no clearing pass is needed and the block is
// ready as soon as reset is released.
// ----------------------------------------------------------------------------
module keyed_record_table_unit #(
  parameter int ENTRIES    = krt_pkg::ENTRIES_DEF,
  parameter int NAME_BYTES = krt_pkg::NAME_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [krt_pkg::MODE_W-1:0]          mode,
  input  logic signed [krt_pkg::KEY_W-1:0]    key,
  input  logic [krt_pkg::NAME_PORT_W-1:0]     name_in,
  output logic                                busy,
  output logic                                done,
  output logic [krt_pkg::STATUS_W-1:0]        status,
  output logic [krt_pkg::NAME_PORT_W-1:0]     name_out
);
  import krt_pkg::*;

  localparam int AW     = $clog2(ENTRIES);
  localparam int CW     = $clog2(ENTRIES + 1);
  localparam int NAME_W = 8 * NAME_BYTES;
  localparam int ROW_W  = KEY_W + NAME_W;
  localparam logic [CW-1:0] FULL_COUNT = CW'(ENTRIES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DISPATCH,
    S_SEARCH,
    S_SHIFT
  } state_t;

  state_t              state;
  op_t                 op;
  logic [KEY_W-1:0]    key_q;
  logic [NAME_W-1:0]   name_q;
  logic [CW-1:0]       entry_count;
  logic [CW-1:0]       rd_idx;
  logic [CW-1:0]       chk_idx;
  logic                chk_vld;

  logic                we;
  logic [AW-1:0]       waddr;
  logic [AW-1:0]       raddr;
  logic [ROW_W-1:0]    wdata;
  logic [ROW_W-1:0]    rdata;
  logic [KEY_W-1:0]    row_key;
  logic [NAME_W-1:0]   row_name;
  logic [CW-1:0]       shift_dst;
  logic [CW-1:0]       last_idx;
  logic                key_hit;
  logic                last_chk;
  logic                rd_more;
  logic                table_full;

  // Record memory: key in the upper bits, name in the lower bits
  krt_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ENTRIES)
  ) u_rec_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Split the read row and run the shared key compare
  assign row_key    = rdata[ROW_W-1 -: KEY_W];
  assign row_name   = rdata[NAME_W-1:0];
  assign key_hit    = chk_vld && (row_key == key_q);
  assign last_idx   = entry_count - CW'(1);
  assign last_chk   = (chk_idx == last_idx);
  assign rd_more    = (rd_idx < entry_count);
  assign table_full = (entry_count == FULL_COUNT);
  assign shift_dst  = chk_idx - CW'(1);

  // Drive the memory ports from the sequencer state
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = {key_q, name_q};
    raddr = rd_idx[AW-1:0];
    unique case (state)
      S_DISPATCH: begin
        raddr = '0;
        if (op == OP_INSERT && !table_full) begin
          we    = 1'b1;
          waddr = entry_count[AW-1:0];
        end
      end
      S_SEARCH: begin
        if (key_hit && op == OP_UPDATE) begin
          we    = 1'b1;
          waddr = chk_idx[AW-1:0];
        end
      end
      S_SHIFT: begin
        if (chk_vld) begin
          we    = 1'b1;
          waddr = shift_dst[AW-1:0];
          wdata = rdata;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer: latch the request, walk the table, post the result word
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      busy        <= 1'b0;
      done        <= 1'b0;
      entry_count <= '0;
      chk_vld     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state  <= S_DISPATCH;
            busy   <= 1'b1;
            op     <= op_t'(mode);
            key_q  <= key;
            name_q <= name_in[NAME_W-1:0];
          end
        end

        S_DISPATCH: begin
          if (op == OP_INSERT) begin
            state    <= S_IDLE;
            busy     <= 1'b0;
            done     <= 1'b1;
            name_out <= '0;
            if (table_full) begin
              status <= ST_FULL;
            end else begin
              status      <= ST_DONE;
              entry_count <= entry_count + CW'(1);
            end
          end else if (entry_count == '0) begin
            state    <= S_IDLE;
            busy     <= 1'b0;
            done     <= 1'b1;
            status   <= ST_MISS;
            name_out <= '0;
          end else begin
            // entry 0 is being read this cycle
            state   <= S_SEARCH;
            rd_idx  <= CW'(1);
            chk_idx <= '0;
            chk_vld <= 1'b1;
          end
        end

        S_SEARCH: begin
          // advance the read pointer one entry per cycle
          chk_idx <= rd_idx;
          chk_vld <= rd_more;
          if (rd_more) begin
            rd_idx <= rd_idx + CW'(1);
          end
          if (key_hit) begin
            unique case (op)
              OP_DELETE: begin
                state   <= S_SHIFT;
                rd_idx  <= chk_idx + CW'(1);
                chk_vld <= 1'b0;
              end
              OP_SELECT: begin
                state    <= S_IDLE;
                busy     <= 1'b0;
                done     <= 1'b1;
                status   <= ST_DONE;
                name_out <= NAME_PORT_W'(row_name);
              end
              OP_INSERT, OP_UPDATE: begin
                state    <= S_IDLE;
                busy     <= 1'b0;
                done     <= 1'b1;
                status   <= ST_DONE;
                name_out <= '0;
              end
            endcase
          end else if (chk_vld && last_chk) begin
            state    <= S_IDLE;
            busy     <= 1'b0;
            done     <= 1'b1;
            status   <= ST_MISS;
            name_out <= '0;
          end
        end

        S_SHIFT: begin
          // move each later record down by one to close the gap
          chk_idx <= rd_idx;
          chk_vld <= rd_more;
          if (rd_more) begin
            rd_idx <= rd_idx + CW'(1);
          end
          if (!rd_more && !chk_vld) begin
            state       <= S_IDLE;
            busy        <= 1'b0;
            done        <= 1'b1;
            status      <= ST_DONE;
            name_out    <= '0;
            entry_count <= last_idx;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/krt_ram.sv -----
// ----------------------------------------------------------------------------
// krt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module krt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [$clog2(DEPTH)-1:0]            waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic [$clog2(DEPTH)-1:0]            raddr,
  output logic [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/krt_checker.sv -----
// ----------------------------------------------------------------------------
// krt_props
// Port-level checks on the keyed record table, bound to the top level.
// ----------------------------------------------------------------------------
module krt_props (
  input logic                                clk,
  input logic                                rst,
  input logic                                start,
  input logic                                busy,
  input logic                                done,
  input logic [krt_pkg::STATUS_W-1:0]        status,
  input logic [krt_pkg::NAME_PORT_W-1:0]     name_out
);
  import krt_pkg::*;

  // An accepted request word holds the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but busy not raised");

  // The result word ends the request: busy is low while it shows
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still busy");

  // Busy only drops together with a result word
  a_busy_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without a result");

  // Only a successful lookup returns a name, and the status is a known code
  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> ((status == ST_DONE) || (status == ST_MISS) || (status == ST_FULL)))
    else $error("unknown status code");

  a_name_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_DONE) |-> (name_out == '0))
    else $error("name returned on a failed request");

endmodule

bind keyed_record_table_unit krt_props u_krt_props (.*);
